@@ design/u8hash_pkg.sv @@
// ============================================================================
// UTF-8 string hash package
// Shared types and constants for the UTF-8 code point hash core.
// ============================================================================
package u8hash_pkg;

    localparam int unsigned HashW  = 32;
    localparam int unsigned CodeW  = 21;
    localparam int unsigned PendW  = 2;
    localparam int unsigned ByteW  = 8;

    // Continuation bytes carry six payload bits each.
    localparam logic [ByteW-1:0] ContMask  = 8'h3F;
    localparam logic [ByteW-1:0] Lead2Mask = 8'h1F;
    localparam logic [ByteW-1:0] Lead3Mask = 8'h0F;
    localparam logic [ByteW-1:0] Lead4Mask = 8'h07;

    // Continuation bytes still expected after a lead byte.
    localparam logic [PendW-1:0] PendNone  = 2'd0;
    localparam logic [PendW-1:0] PendOne   = 2'd1;
    localparam logic [PendW-1:0] PendTwo   = 2'd2;
    localparam logic [PendW-1:0] PendThree = 2'd3;

    // Decoder state carried from one byte to the next.
    typedef struct packed {
        logic [HashW-1:0] running_hash;
        logic [CodeW-1:0] partial_cp;
        logic [PendW-1:0] bytes_pending;
        logic             failed;
    } t_state;

    // One finished string.
    typedef struct packed {
        logic [HashW-1:0] hash_value;
        logic             success;
    } t_result;

endpackage

@@ design/u8hash_if.sv @@
// ============================================================================
// UTF-8 string hash channels
// Valid/ready channels for the byte input and the hash result.
// ============================================================================

// Byte channel: one raw string byte per request.
interface u8hash_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// Result channel: one hash per string.
interface u8hash_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] hash_value;
    logic        success;

    modport source (output valid, output hash_value, output success, input ready);
    modport sink   (input valid, input hash_value, input success, output ready);
endinterface

@@ design/u8hash_step.sv @@
// ============================================================================
// UTF-8 string hash step
// Decodes one byte against the carried state and folds finished code points
// into the running hash.
// ============================================================================
module u8hash_step
    import u8hash_pkg::*;
(
    input  t_state           i_state,
    input  logic [ByteW-1:0] i_data_byte,
    input  logic             i_last_byte,
    output t_state           o_state,
    output t_result          o_result
);

    t_state           s_next;
    logic             s_finish;
    logic [CodeW-1:0] s_fin_cp;
    logic [CodeW-1:0] s_cont_cp;
    logic [HashW-1:0] s_hash_x31;

    assign s_cont_cp  = {i_state.partial_cp[CodeW-7:0], i_data_byte[5:0] & ContMask[5:0]};
    assign s_hash_x31 = {i_state.running_hash[HashW-6:0], 5'b0} - i_state.running_hash;

    // Byte decode: continuation, or classify the lead byte.
    always_comb begin
        s_next   = i_state;
        s_finish = 1'b0;
        s_fin_cp = '0;
        if (i_state.failed) begin
            s_next = i_state;
        end else if (i_state.bytes_pending != PendNone) begin
            s_next.partial_cp    = s_cont_cp;
            s_next.bytes_pending = i_state.bytes_pending - PendOne;
            if (i_state.bytes_pending == PendOne) begin
                s_finish          = 1'b1;
                s_fin_cp          = s_cont_cp;
                s_next.partial_cp = '0;
            end
        end else begin
            unique casez (i_data_byte)
                8'b0???????: begin
                    s_finish = 1'b1;
                    s_fin_cp = CodeW'(i_data_byte);
                    s_next.partial_cp = '0;
                end
                8'b110?????: begin
                    s_next.partial_cp    = CodeW'(i_data_byte & Lead2Mask);
                    s_next.bytes_pending = PendOne;
                end
                8'b1110????: begin
                    s_next.partial_cp    = CodeW'(i_data_byte & Lead3Mask);
                    s_next.bytes_pending = PendTwo;
                end
                8'b11110???: begin
                    s_next.partial_cp    = CodeW'(i_data_byte & Lead4Mask);
                    s_next.bytes_pending = PendThree;
                end
                default: begin
                    s_next.failed        = 1'b1;
                    s_next.partial_cp    = '0;
                    s_next.bytes_pending = PendNone;
                end
            endcase
        end
        // A whole code point: hash = hash * 31 + code point.
        if (s_finish) begin
            s_next.running_hash = s_hash_x31 + HashW'(s_fin_cp);
        end
    end

    // The last byte ends the string and returns the state to its reset value.
    always_comb begin
        o_result.success    = !s_next.failed && (s_next.bytes_pending == PendNone);
        o_result.hash_value = o_result.success ? s_next.running_hash : '0;
        o_state             = i_last_byte ? t_state'('0) : s_next;
    end

endmodule

@@ design/utf8_string_hash_core.sv @@
// ============================================================================
// UTF-8 string hash core
// Java-style 31x string hash over the code points of a UTF-8 byte stream.
// ============================================================================
// The core takes one string byte per request and returns one result per
// string, on the byte flagged last_byte. Bytes flow at one per clock while
// input ready is high: a byte is registered on entry, then decoded and
// folded into the hash state register, and a finished string's result sits
// in an output register until taken. Input ready drops only when the entry
// register holds a last byte while the output register is still full and
// not being taken. A failed string (invalid lead byte or a sequence cut off
// by the last byte) reports success = 0 and a hash of zero. Empty strings
// cannot be sent and are the host's job.
module utf8_string_hash_core
    import u8hash_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    u8hash_in_if.sink         i_byte,
    u8hash_out_if.source      o_hash
);

    logic             r_in_valid;
    logic [ByteW-1:0] r_in_byte;
    logic             r_in_last;
    t_state           r_state;
    logic             r_out_valid;
    t_result          r_out;

    t_state           n_state;
    t_result          n_out;
    logic             s_out_free;
    logic             s_advance;
    logic             s_in_take;

    // Pipeline flow: a non-last byte always moves on; a last byte needs room.
    assign s_out_free = !r_out_valid || o_hash.ready;
    assign s_advance  = r_in_valid && (!r_in_last || s_out_free);
    assign s_in_take  = i_byte.valid && i_byte.ready;

    assign i_byte.ready      = !r_in_valid || s_advance;
    assign o_hash.valid      = r_out_valid;
    assign o_hash.hash_value = r_out.hash_value;
    assign o_hash.success    = r_out.success;

    u8hash_step u_step (
        .i_state     (r_state),
        .i_data_byte (r_in_byte),
        .i_last_byte (r_in_last),
        .o_state     (n_state),
        .o_result    (n_out)
    );

    // Entry register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_in_take) begin
            r_in_valid <= 1'b1;
        end else if (s_advance) begin
            r_in_valid <= 1'b0;
        end
        if (s_in_take) begin
            r_in_byte <= i_byte.data_byte;
            r_in_last <= i_byte.last_byte;
        end
    end

    // Decoder state and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_advance) begin
                r_state <= n_state;
            end
            if (s_advance && r_in_last) begin
                r_out_valid <= 1'b1;
            end else if (o_hash.ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (s_advance && r_in_last) begin
            r_out <= n_out;
        end
    end

endmodule

@@ design/u8hash_chk.sv @@
// ============================================================================
// UTF-8 string hash checker
// Port-level assertions for the hash core, bound to its top level.
// ============================================================================
module u8hash_chk
    import u8hash_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_ready,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic [HashW-1:0] i_hash_value,
    input logic             i_success
);

    // A stalled result holds its request.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_hash_value)
                                           && $stable(i_success)))
        else $error("result changed while stalled");

    // A failed string reports a zero hash.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_success) |-> (i_hash_value == '0))
        else $error("failed result carries a nonzero hash");

    // With room at the output the core never stalls the byte stream.
    a_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_out_valid || i_out_ready) |-> i_in_ready)
        else $error("input stalled although the output has room");

    // Nothing is offered right after reset.
    a_rst_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !i_out_valid)
        else $error("result offered right after reset");

endmodule

bind utf8_string_hash_core u8hash_chk u_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_byte.ready),
    .i_out_valid  (o_hash.valid),
    .i_out_ready  (o_hash.ready),
    .i_hash_value (o_hash.hash_value),
    .i_success    (o_hash.success)
);
